/* rtl/core/sts_pkg.sv */
// Shared widths, rounding constants and the reciprocal factorial table
// for the Taylor series sine pipeline. No dependencies.
package sts_pkg;

    localparam int FRAC_BITS   = 14;
    localparam int MAX_TERMS   = 8;
    localparam int ANGLE_W     = 16;
    localparam int COUNT_W     = 4;
    localparam int SUM_W       = 17;
    localparam int MAG_W       = ANGLE_W + 1;
    localparam int X2_W        = 17;
    localparam int POW_W       = 32;
    localparam int RF_W        = 32;
    localparam int ACC_W       = 20;
    localparam int NUM_STG     = MAX_TERMS + 3;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    localparam int SQ_W = 2 * MAG_W;
    localparam int PP_W = POW_W + X2_W;
    localparam int TP_W = POW_W + RF_W + 1;

    localparam logic [SQ_W-1:0]  SQ_HALF   = SQ_W'(1) << (FRAC_BITS - 1);
    localparam logic [PP_W-1:0]  PP_HALF   = PP_W'(1) << (FRAC_BITS - 1);
    localparam logic [TP_W-1:0]  TP_HALF   = TP_W'(1) << (RF_W - 1);
    localparam logic [PP_W-1:0]  POW_LIMIT = PP_W'(32'h7FFF_FFFF);
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_TERMS);

    localparam logic signed [ACC_W-1:0] SUM_HI = ACC_W'(65535);
    localparam logic signed [ACC_W-1:0] SUM_LO = -ACC_W'(65536);

    // round(2^32 / (2i+1)!); the first term is the power itself
    function automatic logic [RF_W-1:0] recip_fact(input int idx);
        logic [RF_W-1:0] rf;
        case (idx)
            1:       rf = RF_W'(715827883);
            2:       rf = RF_W'(35791394);
            3:       rf = RF_W'(852176);
            4:       rf = RF_W'(11836);
            5:       rf = RF_W'(108);
            6:       rf = RF_W'(1);
            default: rf = '0;
        endcase
        return rf;
    endfunction

endpackage

/* rtl/core/sine_taylor_series.sv */
// Pipelined truncated Taylor series sine in fixed point.
// Depends on sts_pkg for widths, rounding constants and the factorial table.
//
// Usage:
//   s_axis carries one beat per angle: tdata[15:0] angle (signed Q2.14),
//   tdata[19:16] term count, upper bits zero. m_axis returns one beat per
//   input: tdata[16:0] series sum (signed Q3.14), upper bits zero.
//   A count of zero gives zero; counts above eight are taken as eight.
// Stages and throughput:
//   eleven register stages: input capture, squaring, one stage per series
//   term (power update and factorial scaling in parallel multipliers) and
//   output saturation. One beat is taken every cycle while the output is not
//   stalled, set by the per-term stage of one power multiply and one scaling
//   multiply.
// Reset:
//   rst_n clears every stage valid bit; the pipeline comes up empty and
//   ready.
// Back-pressure:
//   each stage holds while the stage after it is full and stalled; empty
//   stages still fill, so s_axis_tready drops only when every stage holds
//   a beat and m_axis_tready is low. Nothing is dropped or repeated.
module sine_taylor_series
    import sts_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // angle[15:0], term_count[19:16]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // series_sum[16:0]
);

    logic                     vld_reg [NUM_STG];
    logic [NUM_STG:0]         rdy;

    logic [MAG_W-1:0]         mag_reg;
    logic                     neg_reg [MAX_TERMS+1];
    logic [COUNT_W-1:0]       cnt_reg [MAX_TERMS+1];
    logic [X2_W-1:0]          x2_reg  [1:MAX_TERMS-1];
    logic [POW_W-1:0]         pow_reg [1:MAX_TERMS];
    logic signed [ACC_W-1:0]  sum_reg [1:NUM_STG-2];
    logic [SUM_W-1:0]         out_reg;

    logic signed [ANGLE_W-1:0] angle_in;
    logic [COUNT_W-1:0]        count_in;
    logic [MAG_W-1:0]          mag_next;
    logic [SQ_W-1:0]           sq_prod;
    logic [SQ_W-1:0]           sq_rnd;
    logic [SUM_W-1:0]          out_next;

    // a stage may load when it is empty or its contents move on
    always_comb
    begin
        rdy[NUM_STG] = m_axis_tready;
        for (int k = NUM_STG - 1; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_STG; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NUM_STG; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // input capture: magnitude, sign and clipped count
    assign angle_in = signed'(s_axis_tdata[ANGLE_W-1:0]);
    assign count_in = s_axis_tdata[ANGLE_W+COUNT_W-1:ANGLE_W];

    always_comb
    begin
        if (angle_in[ANGLE_W-1])
        begin
            mag_next = MAG_W'(-{angle_in[ANGLE_W-1], angle_in});
        end
        else
        begin
            mag_next = MAG_W'({angle_in[ANGLE_W-1], angle_in});
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            mag_reg    <= mag_next;
            neg_reg[0] <= angle_in[ANGLE_W-1];
            cnt_reg[0] <= (count_in > COUNT_MAX) ? COUNT_MAX : count_in;
        end
    end

    // squaring stage
    assign sq_prod = mag_reg * mag_reg;
    assign sq_rnd  = (sq_prod + SQ_HALF) >> FRAC_BITS;

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            x2_reg[1]  <= sq_rnd[X2_W-1:0];
            pow_reg[1] <= POW_W'(mag_reg);
            sum_reg[1] <= '0;
            neg_reg[1] <= neg_reg[0];
            cnt_reg[1] <= cnt_reg[0];
        end
    end

    // one stage per term; stage t+2 adds term t and forms power t+1
    for (genvar t = 0; t < MAX_TERMS; t++)
    begin : g_term
        localparam int K = t + 2;
        localparam bit ODD = (t % 2) == 1;

        logic [POW_W-1:0]        tmag_next;
        logic signed [ACC_W-1:0] term_next;
        logic signed [ACC_W-1:0] sum_next;
        logic                    use_term;

        if (t == 0)
        begin : g_first
            assign tmag_next = pow_reg[K-1];
        end
        else
        begin : g_scaled
            logic [TP_W-1:0] tprod;
            logic [TP_W-1:0] trnd;
            assign tprod     = TP_W'(pow_reg[K-1]) * TP_W'(recip_fact(t));
            assign trnd      = (tprod + TP_HALF) >> RF_W;
            assign tmag_next = trnd[POW_W-1:0];
        end

        assign use_term  = COUNT_W'(t) < cnt_reg[K-1];
        assign term_next = signed'({1'b0, tmag_next[ACC_W-2:0]});

        always_comb
        begin
            if (!use_term)
            begin
                sum_next = sum_reg[K-1];
            end
            else if (neg_reg[K-1] ^ ODD)
            begin
                sum_next = sum_reg[K-1] - term_next;
            end
            else
            begin
                sum_next = sum_reg[K-1] + term_next;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[K])
            begin
                sum_reg[K] <= sum_next;
            end
        end

        if (t < MAX_TERMS - 1)
        begin : g_power
            logic [PP_W-1:0] pprod;
            logic [PP_W-1:0] prnd;
            logic [POW_W-1:0] pow_next;

            assign pprod    = PP_W'(pow_reg[K-1]) * PP_W'(x2_reg[K-1]);
            assign prnd     = (pprod + PP_HALF) >> FRAC_BITS;
            assign pow_next = (prnd > POW_LIMIT) ? POW_LIMIT[POW_W-1:0] : prnd[POW_W-1:0];

            always_ff @(posedge clk)
            begin
                if (rdy[K])
                begin
                    pow_reg[K] <= pow_next;
                    neg_reg[K] <= neg_reg[K-1];
                    cnt_reg[K] <= cnt_reg[K-1];
                end
            end

            if (K < MAX_TERMS)
            begin : g_fwd_x2
                always_ff @(posedge clk)
                begin
                    if (rdy[K])
                    begin
                        x2_reg[K] <= x2_reg[K-1];
                    end
                end
            end
        end
    end

    // output saturation
    always_comb
    begin
        priority if (sum_reg[NUM_STG-2] > SUM_HI)
        begin
            out_next = SUM_HI[SUM_W-1:0];
        end
        else if (sum_reg[NUM_STG-2] < SUM_LO)
        begin
            out_next = SUM_LO[SUM_W-1:0];
        end
        else
        begin
            out_next = sum_reg[NUM_STG-2][SUM_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[NUM_STG-1])
        begin
            out_reg <= out_next;
        end
    end

    assign s_axis_tready = rdy[0];
    assign m_axis_tvalid = vld_reg[NUM_STG-1];
    assign m_axis_tdata  = {{(OUT_TDATA_W-SUM_W){1'b0}}, out_reg};

endmodule

/* tb/testbench.sv */
// Self-checking bench for sine_taylor_series: a queue-fed stream driver, a stream monitor and a
// bit-true fixed point Taylor sine predictor; random idling on both sides of the stream.
// Depends on sts_pkg and the sine_taylor_series RTL.
`timescale 1ns / 100ps

module testbench;
    import sts_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 30;
    localparam int RANDOM_ITEMS = 450;
    localparam int CALM_TAIL = 40;
    localparam logic [63:0] POW_CAP = 64'h7FFF_FFFF;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle;
        logic [COUNT_W-1:0]        term_count;
    } angle_req_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;   // angle[15:0], term_count[19:16]
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;       // series_sum[16:0]

    angle_req_t              angle_queue[$];
    logic signed [SUM_W-1:0] sum_due[$];
    angle_req_t              on_bus;
    int src_gap = 0;
    int sink_gap = 0;
    int src_rate = 0;
    int sink_rate = 0;
    int idle_cycles = 0;
    int errors = 0;

    sine_taylor_series i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 clk = ~clk;

    // partial sum of x - x^3/3! + x^5/5! - ..., sign and magnitude with symmetric rounding
    function automatic logic signed [SUM_W-1:0] taylor_sine(input angle_req_t req);
        longint      x;
        longint      acc;
        logic [63:0] xmag;
        logic [63:0] x2;
        logic [63:0] pmag;
        logic [63:0] tmag;
        logic [63:0] rf;
        logic        neg;
        int          terms;
        x = longint'(req.angle);
        neg = x < 0;
        xmag = 64'(neg ? -x : x);
        x2 = (xmag * xmag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        pmag = xmag;
        acc = 0;
        terms = (req.term_count > MAX_TERMS) ? MAX_TERMS : int'(req.term_count);
        for (int i = 0; i < terms; i++)
        begin
            if (i > 0)
            begin
                pmag = (pmag * x2 + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                if (pmag > POW_CAP)
                    pmag = POW_CAP;
            end
            case (i)
                0:       rf = 64'd4294967296;
                1:       rf = 64'd715827883;
                2:       rf = 64'd35791394;
                3:       rf = 64'd852176;
                4:       rf = 64'd11836;
                5:       rf = 64'd108;
                6:       rf = 64'd1;
                default: rf = 64'd0;
            endcase
            tmag = (pmag * rf + (64'd1 << 31)) >> 32;
            if (neg ^ i[0])
                acc -= longint'(tmag);
            else
                acc += longint'(tmag);
        end
        if (acc > 65535)
            acc = 65535;
        if (acc < -65536)
            acc = -65536;
        return SUM_W'(acc);
    endfunction

    function automatic int pick_rate();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 15;
            default: return 45;
        endcase
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            src_gap = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                sum_due.push_back(taylor_sine(on_bus));
                if ($urandom_range(0, 31) == 0)
                    src_rate = pick_rate();
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (angle_queue.size() == 0)
                    s_axis_tvalid <= 1'b0;
                else if (angle_queue.size() > CALM_TAIL && $urandom_range(0, 99) < src_rate)
                begin
                    src_gap = $urandom_range(1, 8) - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else
                begin
                    on_bus = angle_queue.pop_front();
                    s_axis_tdata  <= IN_TDATA_W'({on_bus.term_count, on_bus.angle});
                    s_axis_tvalid <= 1'b1;
                end
            end
        end
    end

    // monitor and sink back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_gap = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (sum_due.size() == 0)
                begin
                    $error("series_sum: no beat expected, actual %0d",
                           $signed(m_axis_tdata[SUM_W-1:0]));
                    errors++;
                end
                else if (m_axis_tdata[SUM_W-1:0] !== sum_due[0])
                begin
                    $error("series_sum: expected %0d, actual %0d", sum_due[0],
                           $signed(m_axis_tdata[SUM_W-1:0]));
                    errors++;
                    void'(sum_due.pop_front());
                end
                else
                    void'(sum_due.pop_front());
                if ($urandom_range(0, 31) == 0)
                    sink_rate = pick_rate();
            end
            if (sink_gap > 0)
            begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end
            else if (angle_queue.size() > CALM_TAIL && $urandom_range(0, 99) < sink_rate)
            begin
                sink_gap = $urandom_range(1, 8) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        angle_req_t req;
        logic signed [ANGLE_W-1:0] corner_angles[8];
        logic [COUNT_W-1:0]        corner_counts[3];
        corner_angles = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0001,
                          -16'sh0001, 16'sh4000, -16'sh4000, 16'sh5555};
        corner_counts = '{4'd0, 4'd8, 4'd15};

        // the first four corner angles at zero count, full count and an oversized count; the rest at full count only
        foreach (corner_angles[a])
            foreach (corner_counts[c])
                if (a < 4 || c == 1)
                begin
                    req.angle = corner_angles[a];
                    req.term_count = corner_counts[c];
                    angle_queue.push_back(req);
                end
        // each count from one to eight once at the largest negative angle, plus nine, just above the maximum
        for (int n = 1; n <= 9; n++)
        begin
            req.angle = 16'sh8000;
            req.term_count = COUNT_W'(n);
            angle_queue.push_back(req);
        end

        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            case ($urandom_range(0, 9))
                0:       req.angle = ANGLE_W'($urandom_range(0, 63)) ^ {ANGLE_W{$urandom_range(0, 1) == 1}};
                1:       req.angle = 16'sh7FFF - ANGLE_W'($urandom_range(0, 63));
                default: req.angle = ANGLE_W'($urandom_range(0, 65535));
            endcase
            if ($urandom_range(0, 4) == 0)
                req.term_count = COUNT_W'($urandom_range(9, 15));
            else
                req.term_count = COUNT_W'($urandom_range(0, MAX_TERMS));
            angle_queue.push_back(req);
        end

        src_rate = pick_rate();
        sink_rate = pick_rate();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (angle_queue.size() != 0 || s_axis_tvalid || sum_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
